// ===== rtl/mlc_pkg.sv =====
// Package for the mu-law codec: item layouts, constants and action codes.
package mlc_pkg;

    localparam int unsigned PcmW  = 16;
    localparam int unsigned CodeW = 8;
    localparam int unsigned DataW = 24;

    localparam logic [5:0] MuBias = 6'd33;

    typedef enum logic {
        ACT_COMPRESS = 1'b0,
        ACT_EXPAND   = 1'b1
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [CodeW-1:0]  code_in;
        logic [PcmW-1:0]   pcm_sample;
    } t_in_item;

    typedef struct packed {
        logic [PcmW-1:0]   pcm_out;
        logic [CodeW-1:0]  code_out;
    } t_out_item;

endpackage

// ===== rtl/mlc_encoder.sv =====
// Combinational mu-law compressor: 16-bit PCM sample to inverted codeword.
module mlc_encoder (
    input  logic signed [mlc_pkg::PcmW-1:0] i_pcm,
    output logic [mlc_pkg::CodeW-1:0]       o_code
);
    import mlc_pkg::*;

    logic signed [PcmW-1:0] s13;
    logic [PcmW-1:0]        neg_s13;
    logic                   neg;
    logic [13:0]            mag;
    logic [13:0]            biased;
    logic [2:0]             chord;
    logic [3:0]             step;

    always_comb begin
        neg     = i_pcm[PcmW-1];
        s13     = i_pcm >>> 2;
        neg_s13 = PcmW'(16'd0 - s13);
        mag     = neg ? neg_s13[13:0] : s13[13:0];
        biased  = mag + 14'(MuBias);
        chord   = 3'd0;
        for (int i = 5; i <= 12; i++) begin
            if (biased[i]) begin
                chord = 3'(i - 5);
            end
        end
        case (chord)
            3'd0:    step = biased[4:1];
            3'd1:    step = biased[5:2];
            3'd2:    step = biased[6:3];
            3'd3:    step = biased[7:4];
            3'd4:    step = biased[8:5];
            3'd5:    step = biased[9:6];
            3'd6:    step = biased[10:7];
            3'd7:    step = biased[11:8];
            default: step = 4'd0;
        endcase
        if (biased[13]) begin
            chord = 3'd7;
            step  = 4'hF;
        end
        o_code = ~{~neg, chord, step};
    end

endmodule

// ===== rtl/mlc_decoder.sv =====
// Combinational mu-law expander: inverted codeword to 16-bit PCM sample.
module mlc_decoder (
    input  logic [mlc_pkg::CodeW-1:0]        i_code,
    output logic signed [mlc_pkg::PcmW-1:0]  o_pcm
);
    import mlc_pkg::*;

    logic [CodeW-1:0] c;
    logic [2:0]       chord;
    logic [3:0]       step;
    logic [12:0]      biased;
    logic [12:0]      mag;
    logic [PcmW-1:0]  out_mag;

    always_comb begin
        c       = ~i_code;
        chord   = c[6:4];
        step    = c[3:0];
        biased  = (13'd1 << chord) | (13'(step) << ({1'b0, chord} + 4'd1))
                | (13'd32 << chord);
        mag     = biased - 13'(MuBias);
        out_mag = {1'b0, mag, 2'b00};
        o_pcm   = c[7] ? out_mag : PcmW'(16'd0 - out_mag);
    end

endmodule

// ===== rtl/mulaw_audio_codec.sv =====
// Top level of the mu-law codec: input register, compander and result register.
//
//  Channel  Dir  Handshake                 Contents
//  s        in   i_s_tvalid / o_s_tready   tdata {code_in, pcm_sample}, tuser action
//  m        out  o_m_tvalid / i_m_tready   tdata {pcm_out, code_out}
//
// An item passes through the input register and then the result register before
// it can leave; one item can be accepted every cycle while the output is not stalled.
// The input register and the result register advance together whenever the
// result register is empty or its item is being taken.
// Reset clears both valid flags; the block holds a stalled result and keeps
// one more item in the input register.
module mulaw_audio_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [mlc_pkg::DataW-1:0]  i_s_tdata,  // pcm_sample[15:0], code_in[23:16]
    input  logic                       i_s_tuser,  // action[0]
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [mlc_pkg::DataW-1:0]  o_m_tdata   // code_out[7:0], pcm_out[23:8]
);
    import mlc_pkg::*;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      advance;
    logic      in_accept;
    logic [CodeW-1:0] enc_code;
    logic [PcmW-1:0]  dec_pcm;

    mlc_encoder u_enc (
        .i_pcm  (r_s1.pcm_sample),
        .o_code (enc_code)
    );

    mlc_decoder u_dec (
        .i_code (r_s1.code_in),
        .o_pcm  (dec_pcm)
    );

    always_comb begin
        advance     = !r_out_valid || i_m_tready;
        o_s_tready  = advance || !r_s1_valid;
        in_accept   = i_s_tvalid && o_s_tready;
        n_s1_valid  = in_accept || (r_s1_valid && !advance);
        n_out_valid = advance ? r_s1_valid : r_out_valid;
        case (r_s1.action)
            ACT_EXPAND: begin
                n_out.code_out = '0;
                n_out.pcm_out  = dec_pcm;
            end
            default: begin
                n_out.code_out = enc_code;
                n_out.pcm_out  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.action     <= t_action'(i_s_tuser);
            r_s1.pcm_sample <= i_s_tdata[PcmW-1:0];
            r_s1.code_in    <= i_s_tdata[PcmW+CodeW-1:PcmW];
        end
        if (advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

`ifndef SYNTH
    a_fill_empty_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !o_m_tvalid |=> o_m_tvalid)
        else $error("Waiting item did not move into an empty result register.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("Input stalled while the result register was empty.");

    a_one_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:0] == 8'd0 || o_m_tdata[23:8] == 16'd0))
        else $error("Result carries both a codeword and a sample.");
`endif

endmodule

// ===== sim/mulaw_audio_codec_chk.sv =====
// Checker for the mu-law codec: predicts each result from the accepted items and compares.
`timescale 1ns / 100ps

module mulaw_audio_codec_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [mlc_pkg::DataW-1:0]  i_s_tdata,  // pcm_sample[15:0], code_in[23:16]
    input  logic                       i_s_tuser,  // action[0]
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [mlc_pkg::DataW-1:0]  i_m_tdata,  // code_out[7:0], pcm_out[23:8]
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked
);
    import mlc_pkg::*;

    t_out_item companded_q[$];

    function automatic logic [CodeW-1:0] mu_compress(logic signed [PcmW-1:0] sample);
        logic signed [PcmW-1:0] s13;
        logic [PcmW-1:0]        mag;
        logic [PcmW:0]          biased;
        logic [2:0]             chord;
        logic [3:0]             stp;
        int                     b;
        s13    = sample >>> 2;
        mag    = sample[PcmW-1] ? PcmW'(-s13) : PcmW'(s13);
        biased = {1'b0, mag} + (PcmW+1)'(MuBias);
        chord  = 3'd7;
        stp    = 4'hF;
        if (biased < (PcmW+1)'(8192)) begin
            chord = 3'd0;
            for (b = 5; b <= 12; b++) begin
                if (biased[b]) begin
                    chord = 3'(b - 5);
                end
            end
            stp = 4'(biased >> (chord + 1));
        end
        return ~{~sample[PcmW-1], chord, stp};
    endfunction

    function automatic logic [PcmW-1:0] mu_expand(logic [CodeW-1:0] code);
        logic [CodeW-1:0] c;
        logic [2:0]       chord;
        logic [3:0]       stp;
        logic [PcmW-1:0]  biased;
        logic [PcmW-1:0]  mag;
        c      = ~code;
        chord  = c[6:4];
        stp    = c[3:0];
        biased = (PcmW'(1) << chord) | (PcmW'(stp) << (chord + 1))
               | (PcmW'(1) << (chord + 5));
        mag    = (biased - PcmW'(MuBias)) << 2;
        return c[7] ? mag : PcmW'(-mag);
    endfunction

    function automatic t_out_item compand(t_action act, logic [DataW-1:0] data);
        t_out_item r;
        r = '0;
        if (act == ACT_EXPAND) begin
            r.pcm_out = mu_expand(data[PcmW +: CodeW]);
        end else begin
            r.code_out = mu_compress(data[PcmW-1:0]);
        end
        return r;
    endfunction

    initial begin
        o_errors  = 0;
        o_checked = 0;
    end

    assign o_pending = companded_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got = i_m_tdata;
            if (companded_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) begin
                    $display("%0t: unexpected result code_out=%02h pcm_out=%04h",
                             $realtime, got.code_out, got.pcm_out);
                end
            end else begin
                want = companded_q.pop_front();
                o_checked <= o_checked + 1;
                if (got.code_out !== want.code_out || got.pcm_out !== want.pcm_out) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) begin
                        $display("%0t: code_out exp %02h got %02h, pcm_out exp %04h got %04h",
                                 $realtime, want.code_out, got.code_out,
                                 want.pcm_out, got.pcm_out);
                    end
                end
            end
        end
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            companded_q.push_back(compand(t_action'(i_s_tuser), i_s_tdata));
        end
    end

endmodule

// ===== sim/mulaw_audio_codec_tb.sv =====
// Testbench top for the mu-law codec: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module mulaw_audio_codec_tb;
    import mlc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DataW-1:0]   s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DataW-1:0]   m_tdata;

    int n_errors;
    int n_pending;
    int n_checked;
    int n_sent = 0;
    int n_compress = 0;
    int n_expand = 0;
    bit steady;

    assign steady = (n_sent >= 700) && (n_sent < 1000);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mulaw_audio_codec dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    mulaw_audio_codec_chk chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_checked  (n_checked)
    );

    task automatic send_sample(input t_action act, input logic [PcmW-1:0] pcm,
                               input logic [CodeW-1:0] code);
        while (!steady && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, pcm};
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
        if (act == ACT_EXPAND) begin
            n_expand++;
        end else begin
            n_compress++;
        end
        @(negedge i_clk);
    endtask

    initial begin
        int               hold;
        bit               held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                hold = 200;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin
        logic signed [PcmW-1:0] raw;
        logic [PcmW-1:0]        pcm;
        t_action                act;
        int                     i;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(ACT_COMPRESS, 16'sd0, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd1, 8'($urandom));
        send_sample(ACT_COMPRESS, -16'sd1, 8'($urandom));
        send_sample(ACT_COMPRESS, -16'sd4, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd120, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd124, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd32767, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'h8000, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd32632, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'sd32636, 8'($urandom));
        send_sample(ACT_COMPRESS, -16'sd32632, 8'($urandom));
        send_sample(ACT_COMPRESS, -16'sd32636, 8'($urandom));
        send_sample(ACT_COMPRESS, 16'h5555, 8'hFF);
        send_sample(ACT_COMPRESS, 16'hAAAA, 8'h00);
        send_sample(ACT_EXPAND, 16'($urandom), 8'h00);
        send_sample(ACT_EXPAND, 16'($urandom), 8'hFF);
        send_sample(ACT_EXPAND, 16'($urandom), 8'h7F);
        send_sample(ACT_EXPAND, 16'($urandom), 8'h80);
        send_sample(ACT_EXPAND, 16'($urandom), 8'h0F);
        send_sample(ACT_EXPAND, 16'($urandom), 8'hF0);
        send_sample(ACT_EXPAND, 16'hFFFF, 8'h55);
        send_sample(ACT_EXPAND, 16'h0000, 8'hAA);

        for (i = 0; i < 1400; i++) begin
            raw = PcmW'($urandom);
            pcm = (raw >>> $urandom_range(15, 0));
            act = t_action'($urandom_range(1));
            send_sample(act, pcm, 8'($urandom));
        end
        s_tvalid <= 1'b0;

        while (n_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d items (%0d compress, %0d expand) with extremes and saturation cases;",
                 n_sent, n_compress, n_expand);
        $display("checked %0d results under random idling and a long output stall.", n_checked);
        if (n_errors == 0) begin
            $display("mulaw_audio_codec: match");
        end else begin
            $display("mulaw_audio_codec: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("mulaw_audio_codec: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mlc_pkg.sv
rtl/mlc_encoder.sv
rtl/mlc_decoder.sv
rtl/mulaw_audio_codec.sv
sim/mulaw_audio_codec_chk.sv
sim/mulaw_audio_codec_tb.sv
